/* rtl/dhm_pkg.sv */
// Package for the double-hash multimap: transfer structs, op and status codes.
// Used by double_hash_multimap and its checker; no dependencies.
`timescale 1ns / 1ps
package dhm_pkg;

    localparam int TABLE_SIZE_DEF     = 256;
    localparam int VALUES_PER_KEY_DEF = 16;
    localparam int TOTAL_W            = 13;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_LIST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] found_value;
        logic               last;
        logic [TOTAL_W-1:0] total_stored;
    } result_t;

endpackage

/* rtl/double_hash_multimap.sv */
// Double-hash multimap: top level with sequencer, hash remainder unit and memories.
// Depends on dhm_pkg.
`timescale 1ns / 1ps
// Sequence: |key| mod M and mod M-1 on one shared 32x32 multiplier, then one probe
// at a time (registered key/count read, then compare), at most M probes. Remove adds
// a read and a check per scanned value and a read and a write per shifted value;
// search emits one value per read. Unknown op strobes in the cycle after its transfer.
// One command at a time; busy drops in the cycle of the final strobe; results cannot
// be stalled. Async active-low reset clears control, slot-used flags and pair total.
module double_hash_multimap #(
    parameter int TABLE_SIZE     = dhm_pkg::TABLE_SIZE_DEF,
    parameter int VALUES_PER_KEY = dhm_pkg::VALUES_PER_KEY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  dhm_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             valid,
    output dhm_pkg::result_t result
);

    localparam int SW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(VALUES_PER_KEY + 1);
    localparam int AW = (TABLE_SIZE * VALUES_PER_KEY > 1) ?
                        $clog2(TABLE_SIZE * VALUES_PER_KEY) : 1;
    localparam int TW = dhm_pkg::TOTAL_W;

    // reciprocals for exact 32-bit quotients: floor(2^(32+L)/d) + 1, always 2^32 + low word
    localparam int          L1   = $clog2(TABLE_SIZE);
    localparam int          L2   = $clog2(TABLE_SIZE - 1);
    localparam logic [63:0] RCP1 = ((64'd1 << (32 + L1)) / 64'(TABLE_SIZE)) + 64'd1;
    localparam logic [63:0] RCP2 = ((64'd1 << (32 + L2)) / 64'(TABLE_SIZE - 1)) + 64'd1;
    localparam logic [31:0] D1   = 32'(TABLE_SIZE);
    localparam logic [31:0] D2   = 32'(TABLE_SIZE - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIV   = 10'b0000000010,
        S_PRD   = 10'b0000000100,
        S_PCHK  = 10'b0000001000,
        S_RMRD  = 10'b0000010000,
        S_RMCHK = 10'b0000100000,
        S_SHRD  = 10'b0001000000,
        S_SHWR  = 10'b0010000000,
        S_SRRD  = 10'b0100000000,
        S_SROUT = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // memories
    logic [31:0]   key_mem [TABLE_SIZE];
    logic [CW-1:0] cnt_mem [TABLE_SIZE];
    logic [31:0]   val_mem [TABLE_SIZE * VALUES_PER_KEY];
    logic [TABLE_SIZE-1:0] used_reg, used_next;

    logic [1:0]    op_reg, op_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   value_reg, value_next;
    logic [31:0]   mag_reg, mag_next;
    logic [2:0]    step_reg, step_next;
    logic [31:0]   quo_reg, quo_next;
    logic [63:0]   prod_reg, prod_next;
    logic [SW-1:0] r1_reg, r1_next, r2_reg, r2_next;
    logic [SW-1:0] p_reg, p_next;
    logic [SW-1:0] i_reg, i_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] jj_reg, jj_next;
    logic [TW-1:0] total_reg, total_next;

    logic          valid_reg, valid_next;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   fval_reg, fval_next;
    logic          last_reg, last_next;

    logic [31:0]   key_q;
    logic [CW-1:0] cnt_q;
    logic          used_q;
    logic [31:0]   val_q;

    // write ports
    logic          kc_we;
    logic [31:0]   kw_data;
    logic [CW-1:0] cw_data;
    logic          v_we;
    logic [AW-1:0] v_waddr, v_raddr, base;
    logic [31:0]   vw_data;

    // shared multiplier and probe arithmetic
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [32:0] qsum;
    logic [31:0] rem_w;
    logic [SW:0] psum;
    logic [CW:0] jj_inc;

    // step bit 1: back multiply by the modulus, else by the reciprocal; bit 2: modulus M-1
    assign mul_a  = step_reg[1] ? quo_reg : mag_reg;
    assign mul_b  = step_reg[1] ? (step_reg[2] ? D2 : D1) :
                                  (step_reg[2] ? RCP2[31:0] : RCP1[31:0]);
    assign mul_p  = {32'd0, mul_a} * {32'd0, mul_b};
    assign qsum   = {1'b0, mag_reg} + {1'b0, prod_reg[63:32]};
    assign rem_w  = mag_reg - prod_reg[31:0];
    assign psum   = {1'b0, p_reg} + {1'b0, r2_reg} + (SW+1)'(1);
    assign base   = AW'(p_reg) * AW'(VALUES_PER_KEY);
    assign jj_inc = (CW+1)'(jj_reg) + (CW+1)'(1);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        value_next  = value_reg;
        mag_next    = mag_reg;
        step_next   = step_reg;
        quo_next    = quo_reg;
        prod_next   = prod_reg;
        r1_next     = r1_reg;
        r2_next     = r2_reg;
        p_next      = p_reg;
        i_next      = i_reg;
        cnt_next    = cnt_reg;
        jj_next     = jj_reg;
        total_next  = total_reg;
        used_next   = used_reg;
        valid_next  = 1'b0;
        status_next = status_reg;
        fval_next   = 32'd0;
        last_next   = 1'b1;
        kc_we       = 1'b0;
        kw_data     = key_reg;
        cw_data     = cnt_reg;
        v_we        = 1'b0;
        v_waddr     = base + AW'(jj_reg);
        vw_data     = val_q;
        v_raddr     = base + AW'(jj_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = cmd.op;
                    key_next   = cmd.key;
                    value_next = cmd.value;
                    mag_next   = cmd.key[31] ? (32'd0 - cmd.key) : cmd.key;
                    step_next  = '0;
                    if (cmd.op == dhm_pkg::OP_ADD || cmd.op == dhm_pkg::OP_REMOVE ||
                        cmd.op == dhm_pkg::OP_SEARCH)
                        state_next = S_DIV;
                    else
                    begin
                        valid_next  = 1'b1;
                        status_next = dhm_pkg::ST_NOT_FOUND;
                    end
                end
            end
            S_DIV:
            begin
                // per modulus: reciprocal multiply, quotient, back multiply, subtract
                case (step_reg[1:0])
                    2'd0, 2'd2:
                    begin
                        prod_next = mul_p;
                    end
                    2'd1:
                    begin
                        quo_next = step_reg[2] ? 32'(qsum >> L2) : 32'(qsum >> L1);
                    end
                    default:
                    begin
                        if (step_reg[2])
                        begin
                            r2_next    = SW'(rem_w);
                            state_next = S_PRD;
                            i_next     = '0;
                        end
                        else
                            r1_next = SW'(rem_w);
                    end
                endcase
                step_next = step_reg + 3'd1;
            end
            S_PRD:
            begin
                // r1 is the first probe position; later probes step by r2 + 1 modulo M
                if (i_reg == '0)
                    p_next = r1_reg;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (op_reg == dhm_pkg::OP_ADD && !used_q)
                begin
                    kc_we        = 1'b1;
                    cw_data      = CW'(1);
                    used_next[p_reg] = 1'b1;
                    v_we         = 1'b1;
                    v_waddr      = base;
                    vw_data      = value_reg;
                    total_next   = total_reg + TW'(1);
                    valid_next   = 1'b1;
                    status_next  = dhm_pkg::ST_OK;
                    state_next   = S_IDLE;
                end
                else if ((op_reg == dhm_pkg::OP_ADD || used_q) && key_q == key_reg)
                begin
                    cnt_next = cnt_q;
                    jj_next  = '0;
                    if (op_reg == dhm_pkg::OP_ADD)
                    begin
                        valid_next = 1'b1;
                        state_next = S_IDLE;
                        if (cnt_q >= CW'(VALUES_PER_KEY))
                            status_next = dhm_pkg::ST_LIST_FULL;
                        else
                        begin
                            kc_we       = 1'b1;
                            cw_data     = cnt_q + CW'(1);
                            v_we        = 1'b1;
                            v_waddr     = base + AW'(cnt_q);
                            vw_data     = value_reg;
                            total_next  = total_reg + TW'(1);
                            status_next = dhm_pkg::ST_OK;
                        end
                    end
                    else if (op_reg == dhm_pkg::OP_REMOVE)
                        state_next = S_RMRD;
                    else if (cnt_q == '0)
                    begin
                        valid_next  = 1'b1;
                        status_next = dhm_pkg::ST_NOT_FOUND;
                        state_next  = S_IDLE;
                    end
                    else
                        state_next = S_SRRD;
                end
                else if (i_reg == SW'(TABLE_SIZE - 1))
                begin
                    valid_next  = 1'b1;
                    status_next = (op_reg == dhm_pkg::OP_ADD) ?
                                  dhm_pkg::ST_TABLE_FULL : dhm_pkg::ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    p_next     = (psum >= (SW+1)'(TABLE_SIZE)) ?
                                 SW'(psum - (SW+1)'(TABLE_SIZE)) : SW'(psum);
                    i_next     = i_reg + SW'(1);
                    state_next = S_PRD;
                end
            end
            S_RMRD:
            begin
                if (jj_reg >= cnt_reg)
                begin
                    valid_next  = 1'b1;
                    status_next = dhm_pkg::ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_RMCHK;
            end
            S_RMCHK:
            begin
                if (val_q == value_reg)
                    state_next = S_SHRD;
                else
                begin
                    jj_next    = jj_reg + CW'(1);
                    state_next = S_RMRD;
                end
            end
            S_SHRD:
            begin
                v_raddr = base + AW'(jj_inc);
                if (jj_inc < (CW+1)'(cnt_reg))
                    state_next = S_SHWR;
                else
                begin
                    kc_we   = 1'b1;
                    cw_data = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        used_next[p_reg] = 1'b0;
                    if (total_reg != '0)
                        total_next = total_reg - TW'(1);
                    valid_next  = 1'b1;
                    status_next = dhm_pkg::ST_OK;
                    state_next  = S_IDLE;
                end
            end
            S_SHWR:
            begin
                v_we       = 1'b1;
                jj_next    = jj_reg + CW'(1);
                state_next = S_SHRD;
            end
            S_SRRD:
            begin
                state_next = S_SROUT;
            end
            S_SROUT:
            begin
                valid_next  = 1'b1;
                status_next = dhm_pkg::ST_OK;
                fval_next   = val_q;
                last_next   = (jj_inc == (CW+1)'(cnt_reg));
                jj_next     = jj_reg + CW'(1);
                state_next  = last_next ? S_IDLE : S_SRRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        mag_reg    <= mag_next;
        step_reg   <= step_next;
        quo_reg    <= quo_next;
        prod_reg   <= prod_next;
        r1_reg     <= r1_next;
        r2_reg     <= r2_next;
        p_reg      <= p_next;
        i_reg      <= i_next;
        cnt_reg    <= cnt_next;
        jj_reg     <= jj_next;
        status_reg <= status_next;
        fval_reg   <= fval_next;
        last_reg   <= last_next;
    end

    // slot key/count memory, registered read at the probe position
    always_ff @(posedge clk)
    begin
        if (kc_we)
        begin
            key_mem[p_reg] <= kw_data;
            cnt_mem[p_reg] <= cw_data;
        end
        key_q  <= key_mem[p_next];
        cnt_q  <= cnt_mem[p_next];
        used_q <= used_reg[p_next];
    end

    // value memory
    always_ff @(posedge clk)
    begin
        if (v_we)
            val_mem[v_waddr] <= vw_data;
        val_q <= val_mem[v_raddr];
    end

    assign busy                = (state_reg != S_IDLE);
    assign valid               = valid_reg;
    assign result.status       = status_reg;
    assign result.found_value  = fval_reg;
    assign result.last         = last_reg;
    assign result.total_stored = total_reg;

endmodule

/* rtl/dhm_checker.sv */
// Port-level checker for double_hash_multimap, attached by bind.
// Depends on dhm_pkg.
`timescale 1ns / 1ps
module dhm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             valid,
    input dhm_pkg::result_t result
);

    // a command transfer always leaves the block busy or answering at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || valid))
        else $error("accepted command did not start work");

    // the final strobe of a command ends the busy phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && result.last) |-> !busy)
        else $error("busy after final result");

    // a failing status is always a single, final result with no value
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && result.status != dhm_pkg::ST_OK) |->
        (result.last && result.found_value == 32'sd0))
        else $error("failing status with value or not last");

    // after a strobe has ended, the pair total stays stable unless a new strobe comes
    assert property (@(posedge clk) disable iff (!rst_n)
        (!valid && $past(valid)) |=> $stable(result.total_stored) || valid)
        else $error("pair total changed without a result");

endmodule

bind double_hash_multimap dhm_checker u_dhm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .valid  (valid),
    .result (result)
);
